// ===== hw/rtl/hcpe_pkg.sv =====
// ----------------------------------------------------------------------------
// Hill cipher pair encryptor package
// Shared types, constants and alphabet helpers for the pair encryptor.
// ----------------------------------------------------------------------------
package hcpe_pkg;

  localparam int unsigned ByteWidth = 8;
  localparam int unsigned IdxWidth  = 7;
  localparam int unsigned KeyWidth  = 7;
  localparam int unsigned AddrWidth = 4;
  localparam int unsigned DataWidth = 32;

  localparam logic [ByteWidth-1:0] SymSpace   = 8'd32;
  localparam logic [ByteWidth-1:0] SymNewline = 8'd10;
  localparam logic [ByteWidth-1:0] SymTab     = 8'd9;
  localparam logic [ByteWidth-1:0] PrintFirst = 8'd33;
  localparam logic [ByteWidth-1:0] PrintLast  = 8'd126;
  localparam logic [ByteWidth-1:0] IdxOffset  = 8'd30;
  localparam logic [IdxWidth-1:0]  AlphaSize  = 7'd97;

  localparam logic [IdxWidth-1:0] IdxSpace   = 7'd0;
  localparam logic [IdxWidth-1:0] IdxNewline = 7'd1;
  localparam logic [IdxWidth-1:0] IdxTab     = 7'd2;

  typedef enum logic [1:0] {
    RegK00 = 2'd0,
    RegK01 = 2'd1,
    RegK10 = 2'd2,
    RegK11 = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [KeyWidth-1:0] k00;
    logic [KeyWidth-1:0] k01;
    logic [KeyWidth-1:0] k10;
    logic [KeyWidth-1:0] k11;
  } key_t;

  typedef struct packed {
    logic                ok;
    logic [IdxWidth-1:0] idx;
  } sym_t;

  typedef struct packed {
    logic [IdxWidth-1:0] p0;
    logic [IdxWidth-1:0] p1;
    logic                bad;
    logic                fin;
  } pair_t;

  function automatic sym_t byte_to_index(input logic [ByteWidth-1:0] b);
    sym_t s;
    s.ok  = 1'b1;
    s.idx = IdxSpace;
    if (b == SymSpace) begin
      s.idx = IdxSpace;
    end else if (b == SymNewline) begin
      s.idx = IdxNewline;
    end else if (b == SymTab) begin
      s.idx = IdxTab;
    end else if (b >= PrintFirst && b <= PrintLast) begin
      s.idx = IdxWidth'(b - IdxOffset);
    end else begin
      s.ok  = 1'b0;
      s.idx = IdxSpace;
    end
    return s;
  endfunction

  function automatic logic [ByteWidth-1:0] index_to_byte(input logic [IdxWidth-1:0] idx);
    logic [ByteWidth-1:0] b;
    if (idx == IdxSpace) begin
      b = SymSpace;
    end else if (idx == IdxNewline) begin
      b = SymNewline;
    end else if (idx == IdxTab) begin
      b = SymTab;
    end else begin
      b = ByteWidth'(idx) + IdxOffset;
    end
    return b;
  endfunction

  // Reduction mod 97 by folding: 128 is congruent to 31, so the bits above
  // bit 6 are worth 31 each. Four folds bring any 15-bit value below 252,
  // and at most two subtractions of the modulus finish the job.
  function automatic logic [IdxWidth-1:0] mod97(input logic [14:0] x);
    logic [12:0] y1;
    logic [11:0] y2;
    logic [9:0]  y3;
    logic [7:0]  y4;
    y1 = {x[14:7], 5'b0} - 13'(x[14:7]) + 13'(x[6:0]);
    y2 = 12'({y1[12:7], 5'b0}) - 12'(y1[12:7]) + 12'(y1[6:0]);
    y3 = {y2[11:7], 5'b0} - 10'(y2[11:7]) + 10'(y2[6:0]);
    y4 = {y3[9:7], 5'b0} - 8'(y3[9:7]) + 8'(y3[6:0]);
    if (y4 >= 8'({AlphaSize, 1'b0})) begin
      y4 = y4 - 8'({AlphaSize, 1'b0});
    end else if (y4 >= 8'(AlphaSize)) begin
      y4 = y4 - 8'(AlphaSize);
    end
    return y4[IdxWidth-1:0];
  endfunction

endpackage

// ===== hw/rtl/hcpe_if.sv =====
// ----------------------------------------------------------------------------
// Hill cipher pair encryptor stream interfaces
// Plaintext byte channel and ciphertext pair channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hcpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hcpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] cipher_first;
  logic [7:0] cipher_second;
  logic       bad_symbol;
  logic       final_pair;

  modport source (output valid, output cipher_first, output cipher_second,
                  output bad_symbol, output final_pair, input ready);
  modport sink   (input valid, input cipher_first, input cipher_second,
                  input bad_symbol, input final_pair, output ready);
endinterface

// ===== hw/rtl/hill_cipher_pair_encrypt.sv =====
// ----------------------------------------------------------------------------
// Hill cipher pair encryptor
// Pairs plaintext bytes and encrypts each pair with a 2x2 key mod 97.
// ----------------------------------------------------------------------------
// Usage: plaintext bytes enter on in_i, one per transaction, with last_byte
// marking the end of a message. Every second byte completes a pair, and the
// pair leaves on out_o as one transaction of two ciphertext bytes. An odd
// final byte is padded with a space. A byte outside the 97-symbol alphabet
// gives one result with bad_symbol set and both cipher bytes zero; if that
// result does not close the message, the rest of the message is dropped.
// The four key entries are written over the APB port at byte addresses 0,
// 4, 8 and 12, by the user only while no transaction is in flight; the
// block itself does not enforce this. The byte that completes a pair is
// caught in the pair register at its accepting edge, and the result register
// is loaded from the pair register once the result register can advance.
// Throughput is one byte per cycle while the receiver does not stall, set
// by the single arithmetic stage. Reset loads the identity key and clears
// any half-formed pair. When the receiver stalls, both registers hold their
// contents and in_i.ready falls only once both are occupied.
// ----------------------------------------------------------------------------
module hill_cipher_pair_encrypt (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hcpe_in_if.sink                        in_i,
  hcpe_out_if.source                     out_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hcpe_pkg::AddrWidth-1:0] paddr,
  input  logic [hcpe_pkg::DataWidth-1:0] pwdata,
  output logic [hcpe_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);
  import hcpe_pkg::*;

  key_t  key;
  pair_t pair;
  logic  pair_valid;
  logic  adv;

  // Key matrix, written by the host between messages.
  hcpe_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_o   (key)
  );

  // Front end: symbol mapping, pairing, error halting and the pair register.
  hcpe_pair_ctrl u_pair (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .adv_i        (adv),
    .pair_o       (pair),
    .pair_valid_o (pair_valid)
  );

  // Back end: products, reduction mod 97 and the result register.
  hcpe_encrypt_stage u_enc (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_i       (pair),
    .pair_valid_i (pair_valid),
    .key_i        (key),
    .adv_o        (adv),
    .out_o        (out_o)
  );

endmodule

// ===== hw/rtl/hcpe_apb_regs.sv =====
// ----------------------------------------------------------------------------
// Hill cipher pair encryptor key registers
// APB-style register file holding the four entries of the key matrix.
// ----------------------------------------------------------------------------
module hcpe_apb_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [hcpe_pkg::AddrWidth-1:0] paddr,
  input  logic [hcpe_pkg::DataWidth-1:0] pwdata,
  output logic [hcpe_pkg::DataWidth-1:0] prdata,
  output logic                           pready,
  output hcpe_pkg::key_t                 key_o
);
  import hcpe_pkg::*;

  key_t     key_q, key_d;
  logic     wr_en;
  cfg_reg_e sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = cfg_reg_e'(paddr[3:2]);

  always_comb begin
    key_d = key_q;
    if (wr_en) begin
      case (sel)
        RegK00:  key_d.k00 = pwdata[KeyWidth-1:0];
        RegK01:  key_d.k01 = pwdata[KeyWidth-1:0];
        RegK10:  key_d.k10 = pwdata[KeyWidth-1:0];
        RegK11:  key_d.k11 = pwdata[KeyWidth-1:0];
        default: key_d = key_q;
      endcase
    end
  end

  always_comb begin
    case (sel)
      RegK00:  prdata = DataWidth'(key_q.k00);
      RegK01:  prdata = DataWidth'(key_q.k01);
      RegK10:  prdata = DataWidth'(key_q.k10);
      RegK11:  prdata = DataWidth'(key_q.k11);
      default: prdata = '0;
    endcase
  end

  // The key resets to the identity matrix.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q.k00 <= 7'd1;
      key_q.k01 <= 7'd0;
      key_q.k10 <= 7'd0;
      key_q.k11 <= 7'd1;
    end else begin
      key_q <= key_d;
    end
  end

  assign key_o = key_q;

endmodule

// ===== hw/rtl/hcpe_pair_ctrl.sv =====
// ----------------------------------------------------------------------------
// Hill cipher pair encryptor pairing control
// Maps bytes to alphabet indices, pairs them and registers each formed pair.
// ----------------------------------------------------------------------------
module hcpe_pair_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  hcpe_in_if.sink         in_i,
  input  logic            adv_i,
  output hcpe_pkg::pair_t pair_o,
  output logic            pair_valid_o
);
  import hcpe_pkg::*;

  logic [IdxWidth-1:0] held_index_q, held_index_d;
  logic                held_valid_q, held_valid_d;
  logic                held_bad_q, held_bad_d;
  logic                halted_q, halted_d;
  pair_t               pair_q, pair_d;
  logic                pair_valid_q, pair_valid_d;
  logic                acc;
  logic                emit;
  logic                bad;
  sym_t                sym;

  assign in_i.ready = !pair_valid_q || adv_i;
  assign acc        = in_i.valid && in_i.ready;
  assign sym        = byte_to_index(in_i.data_byte);
  assign bad        = held_bad_q || !sym.ok;

  always_comb begin
    held_index_d = held_index_q;
    held_valid_d = held_valid_q;
    held_bad_d   = held_bad_q;
    halted_d     = halted_q;
    pair_d       = pair_q;
    emit         = 1'b0;
    if (acc) begin
      if (halted_q) begin
        // Bytes are dropped until the end of the broken message.
        if (in_i.last_byte) begin
          halted_d     = 1'b0;
          held_valid_d = 1'b0;
          held_bad_d   = 1'b0;
          held_index_d = '0;
        end
      end else if (!held_valid_q) begin
        if (!in_i.last_byte) begin
          held_index_d = sym.idx;
          held_bad_d   = !sym.ok;
          held_valid_d = 1'b1;
        end else begin
          // Odd final byte, padded with a space.
          emit       = 1'b1;
          pair_d.p0  = sym.idx;
          pair_d.p1  = IdxSpace;
          pair_d.bad = !sym.ok;
          pair_d.fin = 1'b1;
        end
      end else begin
        emit         = 1'b1;
        pair_d.p0    = held_index_q;
        pair_d.p1    = sym.idx;
        pair_d.bad   = bad;
        pair_d.fin   = in_i.last_byte;
        held_valid_d = 1'b0;
        held_bad_d   = 1'b0;
        held_index_d = '0;
        if (bad && !in_i.last_byte) begin
          halted_d = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (acc && emit) begin
      pair_valid_d = 1'b1;
    end else if (adv_i) begin
      pair_valid_d = 1'b0;
    end else begin
      pair_valid_d = pair_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_index_q <= '0;
      held_valid_q <= 1'b0;
      held_bad_q   <= 1'b0;
      halted_q     <= 1'b0;
      pair_valid_q <= 1'b0;
    end else begin
      held_index_q <= held_index_d;
      held_valid_q <= held_valid_d;
      held_bad_q   <= held_bad_d;
      halted_q     <= halted_d;
      pair_valid_q <= pair_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q <= pair_d;
  end

  assign pair_o       = pair_q;
  assign pair_valid_o = pair_valid_q;

`ifndef SYNTHESIS
  a_halt_no_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !held_valid_q)
    else $error("held byte present while halted");

  a_pair_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pair_valid_q && !adv_i |=> pair_valid_q && $stable(pair_q))
    else $error("registered pair lost while downstream stalled");
`endif

endmodule

// ===== hw/rtl/hcpe_encrypt_stage.sv =====
// ----------------------------------------------------------------------------
// Hill cipher pair encryptor arithmetic stage
// Matrix product mod 97 of a registered pair, mapped to bytes and registered.
// ----------------------------------------------------------------------------
module hcpe_encrypt_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  hcpe_pkg::pair_t pair_i,
  input  logic            pair_valid_i,
  input  hcpe_pkg::key_t  key_i,
  output logic            adv_o,
  hcpe_out_if.source      out_o
);
  import hcpe_pkg::*;

  logic [13:0]          m00, m01, m10, m11;
  logic [14:0]          sum0, sum1;
  logic [IdxWidth-1:0]  c0, c1;
  logic [ByteWidth-1:0] first_d, first_q;
  logic [ByteWidth-1:0] second_d, second_q;
  logic                 bad_q, fin_q;
  logic                 out_valid_q, out_valid_d;

  assign adv_o = !out_valid_q || out_o.ready;

  assign m00  = 14'(key_i.k00) * 14'(pair_i.p0);
  assign m01  = 14'(key_i.k01) * 14'(pair_i.p1);
  assign m10  = 14'(key_i.k10) * 14'(pair_i.p0);
  assign m11  = 14'(key_i.k11) * 14'(pair_i.p1);
  assign sum0 = 15'(m00) + 15'(m01);
  assign sum1 = 15'(m10) + 15'(m11);
  assign c0   = mod97(sum0);
  assign c1   = mod97(sum1);

  assign first_d  = pair_i.bad ? '0 : index_to_byte(c0);
  assign second_d = pair_i.bad ? '0 : index_to_byte(c1);

  assign out_valid_d = adv_o ? pair_valid_i : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o && pair_valid_i) begin
      first_q  <= first_d;
      second_q <= second_d;
      bad_q    <= pair_i.bad;
      fin_q    <= pair_i.fin;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.cipher_first  = first_q;
  assign out_o.cipher_second = second_q;
  assign out_o.bad_symbol    = bad_q;
  assign out_o.final_pair    = fin_q;

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && bad_q |-> first_q == '0 && second_q == '0)
    else $error("error result carries cipher bytes");

  a_good_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !bad_q |-> first_q != '0 && second_q != '0)
    else $error("cipher byte outside the alphabet");
`endif

endmodule
